>>> sv/drl_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the dense ReLU layer with momentum training.
package drl_pkg;

    localparam int NUM_INPUTS_DEF = 64;
    localparam int NUM_HIDDEN_DEF = 16;

    localparam int DATA_W    = 16;
    localparam int IDX_W     = 11;
    localparam int ACTION_W  = 3;
    localparam int ACC_W     = 48;
    localparam int NODE_MAX_W  = 6;
    localparam int WADDR_MAX_W = 17;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [15:0] LR_RESET  = 16'd655;
    localparam logic [15:0] MOM_RESET = 16'd58982;
    localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

    // register select, taken from paddr[2]
    localparam logic REG_LR  = 1'b0;
    localparam logic REG_MOM = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FEAT  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ERR   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd4;

    localparam logic KIND_ACT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FWD,
        S_UPD,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [IDX_W-1:0]         result_index;
        logic                     result_kind;
        logic                     result_last;
    } t_out_beat;

    // one weight visit travelling down the arithmetic pipeline
    typedef struct packed {
        logic                     valid;
        logic                     upd;
        logic                     first;
        logic                     bias;
        logic [NODE_MAX_W-1:0]    node;
        logic [WADDR_MAX_W-1:0]   addr;
        logic signed [DATA_W-1:0] delta;
    } t_tok;

    typedef struct packed {
        logic                     we;
        logic [WADDR_MAX_W-1:0]   addr;
        logic signed [DATA_W-1:0] weight;
        logic signed [DATA_W-1:0] change;
    } t_wb;

    typedef struct packed {
        logic                     we;
        logic [NODE_MAX_W-1:0]    node;
        logic signed [DATA_W-1:0] value;
    } t_act_wr;

    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/drl_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module drl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/drl_mac.sv
`timescale 1ns / 1ps
// Arithmetic pipeline: dot-product accumulation, activation and momentum weight update.
module drl_mac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  drl_pkg::t_tok             i_tok,
    input  logic signed [15:0]        i_weight,
    input  logic signed [15:0]        i_change,
    input  logic signed [15:0]        i_feature,
    input  logic [31:0]               i_coef,
    input  logic [15:0]               i_mom,
    output drl_pkg::t_wb              o_wb,
    output drl_pkg::t_act_wr          o_act,
    output logic                      o_busy
);
    import drl_pkg::*;

    t_tok r2_tok, r3_tok, r4_tok;
    logic signed [31:0]        r2_p;
    logic signed [DATA_W-1:0]  r2_w, r2_c, r3_w, r4_w, r4_c;
    logic signed [48:0]        r3_m1, r3_m2;
    logic signed [32:0]        r3_m3;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [DATA_W-1:0]  x, b;
    logic signed [31:0]        n_p;
    logic signed [48:0]        n_m1, n_m2;
    logic signed [32:0]        n_m3;
    logic signed [63:0]        t_sum;
    logic signed [DATA_W-1:0]  n_c;
    logic signed [ACC_W-1:0]   rnd;
    logic signed [DATA_W-1:0]  act_sat;

    // stage 1: one shared 16x16 multiplier
    assign x   = i_tok.bias ? ONE_Q12 : i_feature;
    assign b   = i_tok.upd ? i_tok.delta : i_weight;
    assign n_p = 32'(x) * 32'(b);

    // stage 2: split the wide coefficient product
    assign n_m1 = 49'($signed({1'b0, i_coef[15:0]})) * 49'(r2_p);
    assign n_m2 = 49'($signed({1'b0, i_coef[31:16]})) * 49'(r2_p);
    assign n_m3 = 33'($signed({1'b0, i_mom})) * 33'(r2_c);

    // stage 3: combine, round half up at 2^44
    assign t_sum = (64'(r3_m2) <<< 16) + 64'(r3_m1) + (64'(r3_m3) <<< 28)
                 + (64'sd1 <<< 43);
    assign n_c   = sat16(t_sum >>> 44);

    assign rnd     = (r_acc + ACC_W'(2048)) >>> 12;
    assign act_sat = sat16(64'(rnd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tok.valid <= 1'b0;
            r3_tok.valid <= 1'b0;
            r4_tok.valid <= 1'b0;
        end else begin
            r2_tok.valid <= i_tok.valid;
            r3_tok.valid <= r2_tok.valid;
            r4_tok.valid <= r3_tok.valid;
        end
        r2_tok[$bits(t_tok)-2:0] <= i_tok[$bits(t_tok)-2:0];
        r3_tok[$bits(t_tok)-2:0] <= r2_tok[$bits(t_tok)-2:0];
        r4_tok[$bits(t_tok)-2:0] <= r3_tok[$bits(t_tok)-2:0];
        r2_p  <= n_p;
        r2_w  <= i_weight;
        r2_c  <= i_change;
        r3_m1 <= n_m1;
        r3_m2 <= n_m2;
        r3_m3 <= n_m3;
        r3_w  <= r2_w;
        r4_w  <= r3_w;
        r4_c  <= n_c;
        if (r2_tok.valid && !r2_tok.upd) begin
            r_acc <= r2_tok.first ? ACC_W'(r2_p) : r_acc + ACC_W'(r2_p);
        end
    end

    always_comb begin
        o_act.we    = r3_tok.valid && !r3_tok.upd && r3_tok.bias;
        o_act.node  = r3_tok.node;
        o_act.value = (act_sat > 16'sd0) ? act_sat : 16'sd0;
        o_wb.we     = r4_tok.valid && r4_tok.upd;
        o_wb.addr   = r4_tok.addr;
        o_wb.change = r4_c;
        o_wb.weight = sat16(64'(r4_w) - 64'(r4_c));
    end

    assign o_busy = r2_tok.valid | r3_tok.valid | r4_tok.valid;
endmodule

>>> sv/dense_relu_layer_with_momentum_sgd.sv
`timescale 1ns / 1ps
// Top level: dense ReLU layer with momentum training, control and state memories.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+-----------------------
//  input    | in        | i_in_valid / o_in_ready       | i_in_beat  (t_in_beat)
//  result   | out       | o_out_valid / i_out_ready     | o_out_beat (t_out_beat)
//  config   | in        | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Load, feature, error and unused beats are absorbed while idle; a weight read goes
// through S_READ. A forward pass or update walks all (NUM_INPUTS+1)*NUM_HIDDEN
// weights, one per cycle through the memory read port, then drains the arithmetic
// pipeline; a forward pass then emits NUM_HIDDEN result beats, one per accepted beat.
// After reset and after a clear-momentum beat a clearing pass zeroes all
// (NUM_INPUTS+1)*NUM_HIDDEN entries of the change memory; no beat is taken then.
// A stalled result holds in the output register; the input side stays ready while
// the block is idle.
module dense_relu_layer_with_momentum_sgd #(
    parameter int NUM_INPUTS = drl_pkg::NUM_INPUTS_DEF,
    parameter int NUM_HIDDEN = drl_pkg::NUM_HIDDEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  drl_pkg::t_in_beat             i_in_beat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output drl_pkg::t_out_beat            o_out_beat,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [drl_pkg::APB_AW-1:0]    paddr,
    input  logic [drl_pkg::APB_DW-1:0]    pwdata,
    output logic [drl_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import drl_pkg::*;

    localparam int WCOUNT = (NUM_INPUTS + 1) * NUM_HIDDEN;
    localparam int ADDR_W = (WCOUNT > 1) ? $clog2(WCOUNT) : 1;
    localparam int FA_W   = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int ROW_W  = $clog2(NUM_INPUTS + 1);
    localparam int NODE_W = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;

    t_state r_state, n_state;

    logic [15:0]        r_lr, r_mom;
    logic [31:0]        r_coef;
    logic [IDX_W-1:0]   r_idx;
    logic               r_idx_ok;
    logic               r_mode_fwd;
    logic [NODE_W-1:0]  r_node;
    logic [ROW_W-1:0]   r_row;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_clr;
    t_tok               r_tok, n_tok;
    t_out_beat          r_out;
    logic               r_out_valid;
    logic signed [DATA_W-1:0] r_act [NUM_HIDDEN];
    logic signed [DATA_W-1:0] r_err [NUM_HIDDEN];

    logic in_acc, out_free, issue, clearing, busy, row_end, walk_end;
    logic cfg_wr;
    logic [ACTION_W-1:0] act_code;
    logic w_ok, f_ok, e_ok;

    t_wb      wb;
    t_act_wr  act_wr;
    logic     mac_busy;

    logic [DATA_W-1:0] w_rdata, c_rdata, f_rdata;
    logic              w_we, w_re, c_we, f_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr, c_waddr;
    logic [DATA_W-1:0] w_wdata, c_wdata;

    assign act_code = i_in_beat.action;
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign row_end  = (r_row == ROW_W'(NUM_INPUTS));
    assign walk_end = row_end && (r_node == NODE_W'(NUM_HIDDEN - 1));
    assign busy     = r_tok.valid || mac_busy;
    assign w_ok     = 32'(i_in_beat.index) < 32'(WCOUNT);
    assign f_ok     = 32'(i_in_beat.index) < 32'(NUM_INPUTS);
    assign e_ok     = 32'(i_in_beat.index) < 32'(NUM_HIDDEN);

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MOM) ? APB_DW'(r_mom) : APB_DW'(r_lr);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == ADDR_W'(WCOUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (act_code)
                        ACT_FEAT:  if (i_in_beat.last) n_state = S_FWD;
                        ACT_ERR:   if (i_in_beat.last) n_state = S_UPD;
                        ACT_READ:  n_state = S_READ;
                        ACT_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                if (out_free) n_state = S_IDLE;
            end
            S_FWD, S_UPD: begin
                if (walk_end) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!busy) n_state = r_mode_fwd ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free && r_node == NODE_W'(NUM_HIDDEN - 1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state-decoded controls
    always_comb begin
        o_in_ready = 1'b0;
        issue      = 1'b0;
        clearing   = 1'b0;
        unique case (r_state)
            S_IDLE:       o_in_ready = 1'b1;
            S_CLEAR:      clearing   = 1'b1;
            S_FWD, S_UPD: issue      = 1'b1;
            default: begin
            end
        endcase
    end

    // token for the weight visited this cycle; read data lands with it
    always_comb begin
        n_tok.valid = issue;
        n_tok.upd   = (r_state == S_UPD);
        n_tok.first = (r_row == '0);
        n_tok.bias  = row_end;
        n_tok.node  = NODE_MAX_W'(r_node);
        n_tok.addr  = WADDR_MAX_W'(r_addr);
        n_tok.delta = (r_act[r_node] > 16'sd0) ? r_err[r_node] : 16'sd0;
    end

    // memory port selection: beats only arrive while idle, so no overlap
    always_comb begin
        w_we    = wb.we || (in_acc && act_code == ACT_LOAD && w_ok);
        w_waddr = wb.we ? wb.addr[ADDR_W-1:0] : ADDR_W'(i_in_beat.index);
        w_wdata = wb.we ? wb.weight : i_in_beat.value;
        w_re    = issue || (in_acc && act_code == ACT_READ);
        w_raddr = issue ? r_addr : ADDR_W'(i_in_beat.index);
        c_we    = clearing || wb.we;
        c_waddr = clearing ? r_clr : wb.addr[ADDR_W-1:0];
        c_wdata = clearing ? '0 : wb.change;
        f_we    = in_acc && act_code == ACT_FEAT && f_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_lr        <= LR_RESET;
            r_mom       <= MOM_RESET;
            r_out_valid <= 1'b0;
            r_tok.valid <= 1'b0;
            r_mode_fwd  <= 1'b0;
            r_node      <= '0;
            r_row       <= '0;
            r_addr      <= '0;
            for (int i = 0; i < NUM_HIDDEN; i++) r_act[i] <= '0;
        end else begin
            r_state     <= n_state;
            r_tok.valid <= n_tok.valid;

            if (cfg_wr) begin
                if (paddr[2] == REG_MOM) r_mom <= pwdata[15:0];
                else                     r_lr  <= pwdata[15:0];
            end

            if (clearing) r_clr <= r_clr + ADDR_W'(1);

            // start a walk; clear beat restarts the sweep
            if (in_acc) begin
                r_node <= '0;
                r_row  <= '0;
                r_addr <= '0;
                r_mode_fwd <= (act_code == ACT_FEAT);
                if (act_code == ACT_CLEAR) r_clr <= '0;
            end

            // advance row inside a node, then step to the next node's column
            if (issue) begin
                if (row_end) begin
                    r_row  <= '0;
                    r_node <= r_node + NODE_W'(1);
                    r_addr <= ADDR_W'(r_node) + ADDR_W'(1);
                end else begin
                    r_row  <= r_row + ROW_W'(1);
                    r_addr <= r_addr + ADDR_W'(NUM_HIDDEN);
                end
            end

            if (r_state == S_DRAIN) r_node <= '0;

            if (act_wr.we) r_act[act_wr.node[NODE_W-1:0]] <= act_wr.value;

            // result register: load a new beat or drop the taken one
            if (r_state == S_READ && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                r_node      <= r_node + NODE_W'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // payload registers
        r_tok[$bits(t_tok)-2:0] <= n_tok[$bits(t_tok)-2:0];
        r_coef <= 32'((17'(65536) - 17'(r_mom)) * 33'(r_lr));
        if (in_acc) begin
            r_idx    <= i_in_beat.index;
            r_idx_ok <= w_ok;
            if (act_code == ACT_ERR && e_ok) r_err[NODE_W'(i_in_beat.index)] <= i_in_beat.value;
        end
        if (r_state == S_READ && out_free) begin
            r_out.result_value <= r_idx_ok ? w_rdata : '0;
            r_out.result_index <= r_idx;
            r_out.result_kind  <= KIND_READ;
            r_out.result_last  <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out.result_value <= r_act[r_node];
            r_out.result_index <= IDX_W'(r_node);
            r_out.result_kind  <= KIND_ACT;
            r_out.result_last  <= (r_node == NODE_W'(NUM_HIDDEN - 1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    drl_ram #(.WIDTH(DATA_W), .DEPTH(WCOUNT), .AW(ADDR_W)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    drl_ram #(.WIDTH(DATA_W), .DEPTH(WCOUNT), .AW(ADDR_W)) u_change_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (c_rdata)
    );

    drl_ram #(.WIDTH(DATA_W), .DEPTH(NUM_INPUTS), .AW(FA_W)) u_feature_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (FA_W'(i_in_beat.index)),
        .i_wdata (i_in_beat.value),
        .i_re    (issue),
        .i_raddr (FA_W'(r_row)),
        .o_rdata (f_rdata)
    );

    drl_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tok     (r_tok),
        .i_weight  ($signed(w_rdata)),
        .i_change  ($signed(c_rdata)),
        .i_feature ($signed(f_rdata)),
        .i_coef    (r_coef),
        .i_mom     (r_mom),
        .o_wb      (wb),
        .o_act     (act_wr),
        .o_busy    (mac_busy)
    );
endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the dense ReLU layer with momentum training.
module tb_top;
    import drl_pkg::*;

    localparam int NI     = 64;
    localparam int NH     = 16;
    localparam int NW     = (NI + 1) * NH;
    localparam int LIMIT  = 1500000;
    // settle time covers a full weight walk plus pipeline drain, or a clearing pass
    localparam int SETTLE = 2500;

    localparam logic [APB_AW-1:0]   ADDR_LR    = 3'd0;
    localparam logic [APB_AW-1:0]   ADDR_MOM   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_SPARE5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;

    typedef struct {
        t_in_beat  beat;
        bit        fixed;   // expectation typed in below rather than predicted
        t_out_beat want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_beat           i_in_beat = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_beat          o_out_beat;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    dense_relu_layer_with_momentum_sgd dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Shadow copy of the layer: stores and the two training registers
    logic signed [15:0] w_mem    [NW];
    logic signed [15:0] chg_mem  [NW];
    logic signed [15:0] feat_mem [NI];
    logic signed [15:0] act_mem  [NH];
    logic signed [15:0] err_mem  [NH];
    int unsigned        cfg_lr  = LR_RESET;
    int unsigned        cfg_mom = MOM_RESET;

    t_out_beat owed_results[$];
    int        err_count = 0;
    int        cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        random_beats;
    t_row      dir_tab[22];

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Guard against a hung block
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[dense_relu_layer_with_momentum_sgd] ERROR");
            $finish;
        end
    end

    // Receiver: stall at the rate of the current phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        err_count++;
    endtask

    // Compare every accepted result beat with the oldest owed one
    always @(posedge i_clk) begin
        t_out_beat w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result beat", o_out_beat.result_index, -1);
            end else begin
                w = owed_results.pop_front();
                if (o_out_beat.result_value !== w.result_value)
                    report_mismatch("value", o_out_beat.result_value, w.result_value);
                if (o_out_beat.result_index !== w.result_index)
                    report_mismatch("index", o_out_beat.result_index, w.result_index);
                if (o_out_beat.result_kind !== w.result_kind)
                    report_mismatch("kind", o_out_beat.result_kind, w.result_kind);
                if (o_out_beat.result_last !== w.result_last)
                    report_mismatch("last", o_out_beat.result_last, w.result_last);
            end
        end
    end

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Biased dot product per node, rounded to Q4.12, clipped, then ReLU
    task automatic forward_pass();
        longint             acc;
        logic signed [15:0] a;
        for (int n = 0; n < NH; n++) begin
            acc = longint'(w_mem[NI * NH + n]) * 4096;
            for (int r = 0; r < NI; r++)
                acc += longint'(feat_mem[r]) * longint'(w_mem[r * NH + n]);
            a = clip16((acc + 2048) >>> 12);
            if (a <= 0) a = 0;
            act_mem[n] = a;
            owed_results.push_back('{a, 11'(n), KIND_ACT, (n == NH - 1)});
        end
    endtask

    // Momentum step on every weight; gradient only through active nodes
    task automatic momentum_update();
        longint             coef, t, x, delta;
        logic signed [15:0] c;
        int                 addr;
        coef = longint'(65536 - cfg_mom) * longint'(cfg_lr);
        for (int n = 0; n < NH; n++) begin
            delta = (act_mem[n] > 0) ? longint'(err_mem[n]) : 0;
            for (int r = 0; r <= NI; r++) begin
                x    = (r < NI) ? longint'(feat_mem[r]) : 4096;
                addr = r * NH + n;
                t = coef * (x * delta)
                  + longint'(cfg_mom) * longint'(chg_mem[addr]) * (64'sd1 <<< 28);
                c = clip16((t + (64'sd1 <<< 43)) >>> 44);
                chg_mem[addr] = c;
                w_mem[addr]   = clip16(longint'(w_mem[addr]) - longint'(c));
            end
        end
    endtask

    task automatic layer_step(input t_in_beat b);
        case (b.action)
            ACT_LOAD: if (b.index < NW) w_mem[b.index] = b.value;
            ACT_FEAT: begin
                if (b.index < NI) feat_mem[b.index] = b.value;
                if (b.last) forward_pass();
            end
            ACT_ERR: begin
                if (b.index < NH) err_mem[b.index] = b.value;
                if (b.last) momentum_update();
            end
            ACT_READ: owed_results.push_back('{(b.index < NW) ? w_mem[b.index] : 16'sd0,
                                               b.index, KIND_READ, 1'b0});
            ACT_CLEAR: foreach (chg_mem[i]) chg_mem[i] = '0;
            default: ;
        endcase
    endtask

    function automatic t_in_beat mk(input logic [2:0] act, input int idx, input int val,
                                    input bit lst);
        t_in_beat b;
        b.action = act;
        b.index  = idx[IDX_W-1:0];
        b.value  = val[15:0];
        b.last   = lst;
        return b;
    endfunction

    // Mostly small values so activations land in range; extremes and full-width now and then
    function automatic int rnd_value();
        case ($urandom_range(7))
            0: return 32767;
            1: return -32768;
            2, 3: return int'($urandom_range(65535)) - 32768;
            default: return int'($urandom_range(3000)) - 1500;
        endcase
    endfunction

    // Present one beat, hold it until taken, then advance the shadow model.
    // Called just after a rising edge.
    task automatic send_beat(input t_in_beat b, input bit fixed = 0,
                             input t_out_beat want = '0);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (fixed) begin
            owed_results.push_back(want);
            if (b.action == ACT_LOAD && b.index < NW) w_mem[b.index] = b.value;
        end else begin
            layer_step(b);
        end
        random_beats++;
    endtask

    // Drop valid, drain results, let any walk or clearing pass finish
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [APB_AW-1:0] addr, input int unsigned data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LR) cfg_lr = data & 16'hffff;
        else cfg_mom = data & 16'hffff;
    endtask

    // One random burst: mostly well-formed samples, the rest reads, loads and noise
    task automatic random_burst();
        int k;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                k = $urandom_range(0, 4);
                repeat (k) send_beat(mk(ACT_FEAT, ($urandom_range(9) == 0) ?
                    $urandom_range(NI, 2047) : $urandom_range(NI - 1), rnd_value(), 0));
                send_beat(mk(ACT_FEAT, $urandom_range(NI - 1), rnd_value(), 1));
            end
            4, 5, 6: begin
                k = $urandom_range(0, 4);
                repeat (k) send_beat(mk(ACT_ERR, ($urandom_range(9) == 0) ?
                    $urandom_range(NH, 2047) : $urandom_range(NH - 1), rnd_value(), 0));
                send_beat(mk(ACT_ERR, $urandom_range(NH - 1), rnd_value(), 1));
            end
            7: send_beat(mk(ACT_READ, ($urandom_range(3) == 0) ?
                   $urandom_range(2047) : $urandom_range(NW - 1), $urandom_range(65535),
                   $urandom_range(1)));
            8: send_beat(mk(ACT_LOAD, ($urandom_range(5) == 0) ?
                   $urandom_range(2047) : $urandom_range(NW - 1), rnd_value(),
                   $urandom_range(1)));
            default: begin
                if ($urandom_range(2) == 0)
                    send_beat(mk(ACT_CLEAR, $urandom_range(2047), $urandom_range(65535),
                                 $urandom_range(1)));
                else
                    send_beat(mk($urandom_range(ACT_SPARE5, ACT_SPARE7),
                                 $urandom_range(2047), $urandom_range(65535),
                                 $urandom_range(1)));
            end
        endcase
    endtask

    initial begin
        foreach (chg_mem[i]) chg_mem[i] = '0;
        foreach (act_mem[i]) act_mem[i] = '0;

        // Directed rows: extremes, out-of-range indices, spare actions, every operation
        dir_tab[0]  = '{mk(ACT_LOAD, 0, 32767, 0), 0, '0};
        dir_tab[1]  = '{mk(ACT_READ, 0, 0, 0), 1, '{16'sh7fff, 11'd0, KIND_READ, 1'b0}};
        dir_tab[2]  = '{mk(ACT_LOAD, NW - 1, -32768, 1), 0, '0};
        dir_tab[3]  = '{mk(ACT_READ, NW - 1, -1, 1),
                        1, '{16'sh8000, 11'(NW - 1), KIND_READ, 1'b0}};
        dir_tab[4]  = '{mk(ACT_LOAD, NW, 123, 0), 0, '0};
        dir_tab[5]  = '{mk(ACT_READ, NW, 0, 0), 1, '{16'sd0, 11'(NW), KIND_READ, 1'b0}};
        dir_tab[6]  = '{mk(ACT_LOAD, 2047, 5, 0), 0, '0};
        dir_tab[7]  = '{mk(ACT_READ, 2047, 0, 1), 1, '{16'sd0, 11'd2047, KIND_READ, 1'b0}};
        dir_tab[8]  = '{mk(ACT_SPARE5, 3, 77, 0), 0, '0};
        dir_tab[9]  = '{mk(ACT_SPARE7, 2047, -1, 1), 0, '0};
        dir_tab[10] = '{mk(ACT_FEAT, NI, 999, 0), 0, '0};
        dir_tab[11] = '{mk(ACT_FEAT, 2047, 999, 1), 0, '0};
        dir_tab[12] = '{mk(ACT_FEAT, 0, 32767, 0), 0, '0};
        dir_tab[13] = '{mk(ACT_FEAT, NI - 1, -32768, 1), 0, '0};
        dir_tab[14] = '{mk(ACT_ERR, NH, 500, 0), 0, '0};
        dir_tab[15] = '{mk(ACT_ERR, 0, 32767, 0), 0, '0};
        dir_tab[16] = '{mk(ACT_ERR, NH - 1, -32768, 1), 0, '0};
        dir_tab[17] = '{mk(ACT_READ, 0, 0, 0), 0, '0};
        dir_tab[18] = '{mk(ACT_CLEAR, 0, 0, 0), 0, '0};
        dir_tab[19] = '{mk(ACT_ERR, 2047, 0, 1), 0, '0};
        dir_tab[20] = '{mk(ACT_READ, NW - 1, 0, 0), 0, '0};
        dir_tab[21] = '{mk(ACT_FEAT, 5, 4096, 1), 0, '0};

        // Hold reset, then release it; the clearing pass then holds ready low
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every weight, feature and error once so no unwritten entry is ever read
        for (int i = 0; i < NW; i++) send_beat(mk(ACT_LOAD, i, rnd_value(), 0));
        for (int i = 0; i < NI; i++) send_beat(mk(ACT_FEAT, i, rnd_value(), 0));
        for (int i = 0; i < NH; i++) send_beat(mk(ACT_ERR, i, rnd_value(), 0));

        foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].fixed, dir_tab[i].want);
        wait_quiet();

        // Phases: register settings (extremes included) crossed with idling patterns
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    cfg_write(ADDR_LR, 16'hffff);
                    cfg_write(ADDR_MOM, 16'h0000);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    cfg_write(ADDR_LR, 16'h0000);
                    cfg_write(ADDR_MOM, 16'hffff);
                    send_idle_pct = 55; recv_stall_pct = 0;
                end
                2: begin
                    cfg_write(ADDR_LR, $urandom_range(65535));
                    cfg_write(ADDR_MOM, $urandom_range(65535));
                    send_idle_pct = 0;  recv_stall_pct = 55;
                end
                default: begin
                    cfg_write(ADDR_LR, LR_RESET);
                    cfg_write(ADDR_MOM, MOM_RESET);
                    send_idle_pct = 28; recv_stall_pct = 28;
                end
            endcase
            random_beats = 0;
            while (random_beats < 55) random_burst();
            wait_quiet();
        end

        if (err_count == 0) begin
            $display("[dense_relu_layer_with_momentum_sgd] OK");
        end else begin
            $display("[dense_relu_layer_with_momentum_sgd] ERROR");
        end
        $finish;
    end
endmodule
